### hw/rtl/lz_escape_code_decompressor_core_defines.svh
// ----------------------------------------------------------------------------
// LZ escape-code decompressor assertion macros
// Shared concurrent assertion forms; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LZ_ESCAPE_CODE_DECOMPRESSOR_CORE_DEFINES_SVH
`define LZ_ESCAPE_CODE_DECOMPRESSOR_CORE_DEFINES_SVH

// same-cycle implication
`define LZD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzd assertion failed");

// next-cycle implication
`define LZD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzd assertion failed");

`endif

### hw/rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Types and constants shared by the decompressor front end, queue and back end.
// ----------------------------------------------------------------------------
package lzd_pkg;

	localparam int LZD_WINDOW_DEPTH = 65536;
	localparam int LZD_QDEPTH       = 2;
	localparam int LZD_HDR_LEN      = 9;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_IDLE,
		PH_KEY,
		PH_LEN,
		PH_DIST,
		PH_COPY,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LIT,
		CMD_COPY
	} cmd_kind_t;

	typedef enum logic [1:0] {
		FAULT_NONE,
		FAULT_DIST,
		FAULT_REJECT
	} fault_t;

	// one classified beat handed from front to back
	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] lit;
		logic       copy_pending;
		logic       stream_done;
		fault_t     fault;
	} cmd_t;

endpackage

### hw/rtl/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// Header parser and token decoder; classifies each beat and tracks history
// pointers, producing one command per accepted beat.
// ----------------------------------------------------------------------------
module lzd_front import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = LZD_WINDOW_DEPTH,
	parameter int AW = $clog2(WINDOW_DEPTH),
	parameter int CW = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [7:0]    data_byte,
	input  logic          q_full,
	output logic          q_push,
	output cmd_t          q_cmd,
	output logic [AW-1:0] q_src
);

	localparam int SW = CW + 1;
	localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_DEPTH - 1);

	phase_t        phase_q, phase_d;
	logic [3:0]    hcnt_q, hcnt_d;
	logic [31:0]   sleft_q, sleft_d;
	logic [7:0]    key_q, key_d;
	logic [7:0]    code_q, code_d;
	logic [13:0]   len_q, len_d;
	logic [23:0]   acc_q, acc_d;
	logic [1:0]    obl_q, obl_d;
	logic [CW-1:0] cdist_q, cdist_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [CW-1:0] wc_q, wc_d;

	logic [31:0]   sl_dec;
	phase_t        end_ph, copy_end_ph;
	logic [7:0]    code_k, ab_code;
	logic [1:0]    ab_n, pos;
	logic [23:0]   acc_dist, sc_acc;
	logic [24:0]   dist_full;
	logic          dist_bad;
	logic [13:0]   len_al;
	logic          sc_now, hist_wr;
	logic [SW-1:0] wp_ext, cd_ext, src_sum;

	function automatic logic [1:0] dist_bytes(input logic [7:0] code);
		logic [1:0] s;
		s = code[1:0];
		return (s == 2'd3) ? 2'd0 : s + 2'd1;
	endfunction

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// shared decode terms
	always_comb begin
		sl_dec      = (sleft_q != 32'd0) ? sleft_q - 32'd1 : 32'd0;
		end_ph      = (sl_dec == 32'd0) ? PH_DONE : PH_IDLE;
		copy_end_ph = (sleft_q == 32'd0) ? PH_DONE : PH_IDLE;
		code_k      = (data_byte > key_q) ? data_byte - 8'd1 : data_byte;
		ab_code     = (phase_q == PH_KEY) ? code_k : code_q;
		ab_n        = dist_bytes(ab_code);
		len_al      = (phase_q == PH_KEY) ? {9'd0, code_k[7:3]}
		                                  : (len_q | {1'b0, data_byte, 5'd0});
		pos         = dist_bytes(code_q) - obl_q;
		acc_dist    = acc_q | (24'(data_byte) << {pos, 3'b000});
		sc_acc      = (phase_q == PH_DIST) ? acc_dist : 24'd0;
		dist_full   = {1'b0, sc_acc} + 25'd1;
		dist_bad    = (dist_full > 25'(WINDOW_DEPTH)) || (dist_full > 25'(wc_q));
		unique case (phase_q)
			PH_KEY:  sc_now = !op && (data_byte != key_q) && !code_k[2] && (ab_n == 2'd0);
			PH_LEN:  sc_now = !op && (ab_n == 2'd0);
			PH_DIST: sc_now = !op && (obl_q == 2'd1);
			default: sc_now = 1'b0;
		endcase
		if (op) begin
			hist_wr = (phase_q == PH_COPY);
		end else begin
			hist_wr = ((phase_q == PH_IDLE) && (data_byte != key_q)) ||
			          ((phase_q == PH_KEY) && (data_byte == key_q));
		end
		wp_ext  = SW'(wp_q);
		cd_ext  = SW'(cdist_q);
		src_sum = (wp_ext >= cd_ext) ? wp_ext - cd_ext
		                             : wp_ext + SW'(WINDOW_DEPTH) - cd_ext;
	end

	// next state
	always_comb begin
		logic do_al;
		logic do_sc;
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		sleft_d = sleft_q;
		key_d   = key_q;
		code_d  = code_q;
		len_d   = len_q;
		acc_d   = acc_q;
		obl_d   = obl_q;
		cdist_d = cdist_q;
		wp_d    = wp_q;
		wc_d    = wc_q;
		do_al   = 1'b0;
		do_sc   = 1'b0;
		if (op) begin
			if (phase_q == PH_COPY) begin
				len_d = len_q - 14'd1;
				if (len_q == 14'd1) phase_d = copy_end_ph;
			end
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hcnt_q[3:2] == 2'b01)
						sleft_d = sleft_q | (32'(data_byte) << {hcnt_q[1:0], 3'b000});
					if (hcnt_q[3]) begin
						key_d   = data_byte;
						sleft_d = sleft_q - 32'(LZD_HDR_LEN);
						hcnt_d  = 4'd0;
						phase_d = (sleft_q == 32'(LZD_HDR_LEN)) ? PH_DONE : PH_IDLE;
					end else begin
						hcnt_d = hcnt_q + 4'd1;
					end
				end
				PH_IDLE: begin
					sleft_d = sl_dec;
					phase_d = (data_byte != key_q) ? end_ph : PH_KEY;
				end
				PH_KEY: begin
					sleft_d = sl_dec;
					if (data_byte == key_q) begin
						phase_d = end_ph;
					end else begin
						code_d = code_k;
						if (code_k[2]) begin
							len_d   = {9'd0, code_k[7:3]};
							phase_d = PH_LEN;
						end else begin
							do_al = 1'b1;
						end
					end
				end
				PH_LEN: begin
					sleft_d = sl_dec;
					do_al   = 1'b1;
				end
				PH_DIST: begin
					sleft_d = sl_dec;
					acc_d   = acc_dist;
					obl_d   = obl_q - 2'd1;
					if (obl_q == 2'd1) do_sc = 1'b1;
				end
				default: ;
			endcase
		end
		if (do_al) begin
			len_d = len_al + 14'd4;
			acc_d = 24'd0;
			obl_d = ab_n;
			if (ab_n == 2'd0) do_sc = 1'b1;
			else phase_d = PH_DIST;
		end
		if (do_sc) begin
			if (dist_bad) begin
				len_d   = 14'd0;
				phase_d = end_ph;
			end else begin
				phase_d = PH_COPY;
				cdist_d = CW'(dist_full);
			end
		end
		if (hist_wr) begin
			wp_d = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
			if (wc_q != CW'(WINDOW_DEPTH)) wc_d = wc_q + CW'(1);
		end
	end

	// command outputs
	always_comb begin
		q_cmd.kind  = CMD_NONE;
		q_cmd.lit   = 8'd0;
		q_cmd.fault = FAULT_NONE;
		if (hist_wr) begin
			if (op) begin
				q_cmd.kind = CMD_COPY;
			end else begin
				q_cmd.kind = CMD_LIT;
				q_cmd.lit  = data_byte;
			end
		end
		if (!op && ((phase_q == PH_COPY) || (phase_q == PH_DONE)))
			q_cmd.fault = FAULT_REJECT;
		else if (sc_now && dist_bad)
			q_cmd.fault = FAULT_DIST;
		q_cmd.copy_pending = (phase_d == PH_COPY);
		q_cmd.stream_done  = (phase_d == PH_DONE);
		q_src              = AW'(src_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcnt_q  <= '0;
			sleft_q <= '0;
			key_q   <= '0;
			code_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			obl_q   <= '0;
			cdist_q <= '0;
			wp_q    <= '0;
			wc_q    <= '0;
		end else if (q_push) begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			sleft_q <= sleft_d;
			key_q   <= key_d;
			code_q  <= code_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
			obl_q   <= obl_d;
			cdist_q <= cdist_d;
			wp_q    <= wp_d;
			wc_q    <= wc_d;
		end
	end

endmodule

### hw/rtl/lzd_fifo.sv
// ----------------------------------------------------------------------------
// lzd_fifo
// Short command queue between the front end and the history back end.
// ----------------------------------------------------------------------------
module lzd_fifo import lzd_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         dout_valid,
	output logic [W-1:0] dout
);

	localparam int PW = (LZD_QDEPTH > 1) ? $clog2(LZD_QDEPTH) : 1;
	localparam int NW = $clog2(LZD_QDEPTH + 1);
	localparam logic [PW-1:0] P_LAST = PW'(LZD_QDEPTH - 1);

	logic [W-1:0]  data_q [LZD_QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;

	assign full       = (cnt_q == NW'(LZD_QDEPTH));
	assign dout_valid = (cnt_q != '0);
	assign dout       = data_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) data_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == P_LAST) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == P_LAST) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + NW'(1);
			else if (pop && !push) cnt_q <= cnt_q - NW'(1);
		end
	end

endmodule

### hw/rtl/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// History memory and result stage; reads copy sources, writes every emitted
// byte back into the window and holds the result beat.
// ----------------------------------------------------------------------------
`include "lz_escape_code_decompressor_core_defines.svh"

module lzd_back import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = LZD_WINDOW_DEPTH,
	parameter int AW = $clog2(WINDOW_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  cmd_t          q_cmd,
	input  logic [AW-1:0] q_src,
	output logic          q_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          copy_pending,
	output logic          stream_done,
	output logic [1:0]    fault
);

	localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_DEPTH - 1);

	logic [7:0]    hist_mem [WINDOW_DEPTH];
	logic [AW-1:0] wp_q;

	logic          v_s1;
	cmd_t          cmd_s1;
	logic [7:0]    rd_s1;
	logic          fwd_s1;
	logic [7:0]    fwdb_s1;

	logic          res_valid_q;
	cmd_t          res_q;

	logic          adv_s1, load_s1, hist_we;
	logic [7:0]    byte_s1;

	assign adv_s1  = v_s1 && (!res_valid_q || res_ready);
	assign load_s1 = !v_s1 || adv_s1;
	assign q_pop   = load_s1 && q_valid;
	assign hist_we = adv_s1 && (cmd_s1.kind != CMD_NONE);

	always_comb begin
		if (cmd_s1.kind == CMD_COPY) byte_s1 = fwd_s1 ? fwdb_s1 : rd_s1;
		else byte_s1 = cmd_s1.lit;
	end

	// history: write the retiring byte, read the next copy source
	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[wp_q] <= byte_s1;
		if (q_pop) begin
			rd_s1   <= hist_mem[q_src];
			cmd_s1  <= q_cmd;
			fwd_s1  <= hist_we && (wp_q == q_src);
			fwdb_s1 <= byte_s1;
		end
		if (adv_s1) begin
			res_q.kind         <= cmd_s1.kind;
			res_q.lit          <= byte_s1;
			res_q.copy_pending <= cmd_s1.copy_pending;
			res_q.stream_done  <= cmd_s1.stream_done;
			res_q.fault        <= cmd_s1.fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (hist_we) wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
			if (load_s1) v_s1 <= q_valid;
			if (adv_s1) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_valid    = (res_q.kind != CMD_NONE);
	assign out_byte     = res_q.lit;
	assign copy_pending = res_q.copy_pending;
	assign stream_done  = res_q.stream_done;
	assign fault        = res_q.fault;

	`LZD_ASSERT_SAME(a_idle_byte_zero, res_valid_q && (res_q.kind == CMD_NONE), res_q.lit == 8'd0)
	`LZD_ASSERT_SAME(a_done_no_copy, res_valid_q && res_q.stream_done, !res_q.copy_pending)
	`LZD_ASSERT_SAME(a_reject_no_byte, res_valid_q && (res_q.fault == FAULT_REJECT), res_q.kind == CMD_NONE)
	`LZD_ASSERT_NEXT(a_adv_fills_res, adv_s1, res_valid_q)

endmodule

### hw/rtl/lz_escape_code_decompressor_core.sv
// Path: an accepted beat passes the queue, the history read stage and the result
// register. Throughput: one beat per cycle while res_ready is held high, set by
// the single history port pair (one write and one registered read per cycle).
// Reset: arst_n clears the decoder state, queue and result stage at once;
// the history window is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// lz_escape_code_decompressor_core
// Escape-byte LZ77 stream decoder: front end classifies beats, a short queue
// decouples it from the history back end that emits the result beats.
// ----------------------------------------------------------------------------
module lz_escape_code_decompressor_core import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = LZD_WINDOW_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] data_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       copy_pending,
	output logic       stream_done,
	output logic [1:0] fault
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int CMDW = $bits(cmd_t);
	localparam int FW = CMDW + AW;

	logic          q_full, q_push, q_pop, q_valid;
	cmd_t          f_cmd, b_cmd;
	logic [AW-1:0] f_src, b_src;
	logic [FW-1:0] q_din, q_dout;

	lzd_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data_byte(data_byte),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(f_cmd),
		.q_src(f_src)
	);

	assign q_din = {f_src, f_cmd};

	lzd_fifo #(
		.W(FW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(q_din),
		.full(q_full),
		.pop(q_pop),
		.dout_valid(q_valid),
		.dout(q_dout)
	);

	assign b_src = q_dout[FW-1:CMDW];
	assign b_cmd = cmd_t'(q_dout[CMDW-1:0]);

	lzd_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(b_cmd),
		.q_src(b_src),
		.q_pop(q_pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.copy_pending(copy_pending),
		.stream_done(stream_done),
		.fault(fault)
	);

endmodule
